// File: rtl/core/demand_paging_fault_handler_macros.svh
// Assertion macros shared by the fault handler RTL.
// Needs clk and rst_n in scope where a macro is used.
`ifndef DEMAND_PAGING_FAULT_HANDLER_MACROS_SVH
`define DEMAND_PAGING_FAULT_HANDLER_MACROS_SVH
`ifndef SYNTHESIS
`define DPFH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DPFH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DPFH_ASSERT_IMP(lbl, ante, cons, msg)
`define DPFH_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/core/dpfh_pkg.sv
// Types, sizes and codes for the demand paging fault handler.
// No dependencies.
package dpfh_pkg;

    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
    localparam int FRAME_W    = 20;
    localparam int WANT_W     = 4;
    localparam int RIGHTS_W   = 3;
    localparam int CFG_IDX_W  = 3;

    localparam int TABLE_POOL     = 64;
    localparam int DIRECTORY_BITS = 12;
    localparam int SECOND_BITS    = 8;

    localparam int DIR_SIZE    = 1 << DIRECTORY_BITS;
    localparam int DIR_LO      = PAGE_SHIFT + SECOND_BITS;
    localparam int TBL_W       = (TABLE_POOL > 1) ? $clog2(TABLE_POOL) : 1;
    localparam int TIU_W       = $clog2(TABLE_POOL + 1);
    localparam int DIR_ENT_W   = 1 + TBL_W;
    localparam int PAGE_ENT_W  = 1 + FRAME_W;
    localparam int SLOT_AW     = TBL_W + SECOND_BITS;
    localparam int SLOT_DEPTH  = 1 << SLOT_AW;
    localparam int CLR_COUNT   = (DIR_SIZE > SLOT_DEPTH) ? DIR_SIZE : SLOT_DEPTH;
    localparam int CLR_W       = $clog2(CLR_COUNT);

    localparam logic [RIGHTS_W-1:0] RIGHTS_FULL = 3'd7;
    localparam logic [RIGHTS_W-1:0] RIGHTS_RW   = 3'd6;
    localparam logic [RIGHTS_W-1:0] RIGHTS_NONE = 3'd0;

    localparam logic [ADDR_W-1:0] VSTART_RST = 32'h0200_0000;
    localparam logic [ADDR_W-1:0] HSTART_RST = 32'h0400_0000;
    localparam logic [ADDR_W-1:0] HEND_RST   = 32'h0440_0000;
    localparam logic [ADDR_W-1:0] SEND_RST   = 32'hBFF0_0000;
    localparam logic [ADDR_W-1:0] STOP_RST   = 32'hC000_0000;

    typedef enum logic [2:0] {
        ST_DIRECT   = 3'd0,
        ST_EXISTING = 3'd1,
        ST_NEW      = 3'd2,
        ST_NO_FRAME = 3'd3,
        ST_NO_TABLE = 3'd4
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VSTART = 3'd0,
        REG_HSTART = 3'd1,
        REG_HEND   = 3'd2,
        REG_SEND   = 3'd3,
        REG_STOP   = 3'd4
    } cfg_idx_t;

    // Operand pairs for the shared less-than unit
    typedef enum logic [2:0] {
        CMP_VSTART = 3'd0,   // addr < vstart
        CMP_HSTART = 3'd1,   // addr < hstart
        CMP_HEND   = 3'd2,   // addr < hend
        CMP_SEND   = 3'd3,   // send < addr
        CMP_STOP   = 3'd4    // stop < addr
    } cmp_sel_t;

    typedef struct packed {
        logic [ADDR_W-1:0] vstart;
        logic [ADDR_W-1:0] hstart;
        logic [ADDR_W-1:0] hend;
        logic [ADDR_W-1:0] send;
        logic [ADDR_W-1:0] stop;
    } cfg_regs_t;

endpackage

// File: rtl/core/dpfh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dpfh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/dpfh_cmp.sv
// Shared unsigned less-than unit for the region checks.
// Depends on dpfh_pkg.
module dpfh_cmp (
    input  logic [dpfh_pkg::ADDR_W-1:0] addr,
    input  dpfh_pkg::cfg_regs_t         cfg,
    input  dpfh_pkg::cmp_sel_t          sel,
    output logic                        lt
);

    logic [dpfh_pkg::ADDR_W-1:0] op_a;
    logic [dpfh_pkg::ADDR_W-1:0] op_b;
    logic [dpfh_pkg::ADDR_W:0]   diff;

    always_comb
    begin
        unique case (sel)
            dpfh_pkg::CMP_VSTART:
            begin
                op_a = addr;
                op_b = cfg.vstart;
            end
            dpfh_pkg::CMP_HSTART:
            begin
                op_a = addr;
                op_b = cfg.hstart;
            end
            dpfh_pkg::CMP_HEND:
            begin
                op_a = addr;
                op_b = cfg.hend;
            end
            dpfh_pkg::CMP_SEND:
            begin
                op_a = cfg.send;
                op_b = addr;
            end
            dpfh_pkg::CMP_STOP:
            begin
                op_a = cfg.stop;
                op_b = addr;
            end
            default:
            begin
                op_a = addr;
                op_b = addr;
            end
        endcase
    end

    // borrow out of a - b means a < b
    assign diff = {1'b0, op_a} - {1'b0, op_b};
    assign lt   = diff[dpfh_pkg::ADDR_W];

endmodule

// File: rtl/core/demand_paging_fault_handler.sv
// Page fault handler: region rights plus a two-level page table walk.
// From accept, a direct-mapped fault or a fault with no table left passes S_CMP, S_DIR and
// S_OUT to result valid, a walked fault also S_PWAIT and S_PAGE; in_ready returns with the
// result, so a new fault is taken only once the last result is loaded. A held result stalls input.
// Five region compares share one comparator, then the directory RAM and, for a walked fault, the page RAM are read.
// Reset sets all registers to their reset values; a clearing pass then zeroes both RAMs.
`include "demand_paging_fault_handler_macros.svh"
module demand_paging_fault_handler (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dpfh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dpfh_pkg::ADDR_W-1:0]         cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dpfh_pkg::ADDR_W-1:0]         fault_address,
    input  logic [dpfh_pkg::WANT_W-1:0]         access_wanted,
    input  logic                                requester_is_root,
    input  logic [dpfh_pkg::FRAME_W-1:0]        offered_frame,
    input  logic                                frame_available,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [dpfh_pkg::PAGE_W-1:0]         virtual_page,
    output logic [dpfh_pkg::FRAME_W-1:0]        physical_frame,
    output logic [dpfh_pkg::RIGHTS_W-1:0]       rights,
    output logic                                access_denied,
    output logic                                frame_taken,
    output logic [2:0]                          status
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CMP,
        S_DIR,
        S_PWAIT,
        S_PAGE,
        S_OUT
    } state_t;

    state_t                               state_reg, state_next;
    dpfh_pkg::cfg_regs_t                  cfg_reg, cfg_next;
    logic [dpfh_pkg::CLR_W-1:0]           clr_reg, clr_next;
    logic [dpfh_pkg::TIU_W-1:0]           tiu_reg, tiu_next;
    dpfh_pkg::cmp_sel_t                   sel_reg, sel_next;

    logic [dpfh_pkg::ADDR_W-1:0]          addr_reg, addr_next;
    logic [dpfh_pkg::WANT_W-1:0]          want_reg, want_next;
    logic                                 root_reg, root_next;
    logic [dpfh_pkg::FRAME_W-1:0]         offer_reg, offer_next;
    logic                                 avail_reg, avail_next;

    logic lt_vs_reg, lt_vs_next;
    logic lt_hs_reg, lt_hs_next;
    logic lt_he_reg, lt_he_next;
    logic gt_se_reg, gt_se_next;
    logic gt_st_reg, gt_st_next;

    logic [dpfh_pkg::TBL_W-1:0]           table_reg, table_next;
    logic [dpfh_pkg::RIGHTS_W-1:0]        region_reg, region_next;
    logic [dpfh_pkg::FRAME_W-1:0]         res_frame_reg, res_frame_next;
    logic [dpfh_pkg::RIGHTS_W-1:0]        res_rights_reg, res_rights_next;
    logic                                 res_taken_reg, res_taken_next;
    dpfh_pkg::status_t                    res_status_reg, res_status_next;

    logic                                 out_valid_reg, out_valid_next;
    logic [dpfh_pkg::PAGE_W-1:0]          page_out_reg, page_out_next;
    logic [dpfh_pkg::FRAME_W-1:0]         frame_out_reg, frame_out_next;
    logic [dpfh_pkg::RIGHTS_W-1:0]        rights_out_reg, rights_out_next;
    logic                                 denied_reg, denied_next;
    logic                                 taken_out_reg, taken_out_next;
    dpfh_pkg::status_t                    status_out_reg, status_out_next;

    logic                                 cmp_lt;
    logic [dpfh_pkg::RIGHTS_W-1:0]        region_calc;
    logic [dpfh_pkg::DIRECTORY_BITS-1:0]  dir_idx;
    logic [dpfh_pkg::SECOND_BITS-1:0]     sec_idx;
    logic [dpfh_pkg::SLOT_AW-1:0]         slot_addr;

    logic                                 dir_we;
    logic [dpfh_pkg::DIRECTORY_BITS-1:0]  dir_waddr;
    logic [dpfh_pkg::DIR_ENT_W-1:0]       dir_wdata;
    logic [dpfh_pkg::DIR_ENT_W-1:0]       dir_rdata;
    logic                                 page_we;
    logic [dpfh_pkg::SLOT_AW-1:0]         page_waddr;
    logic [dpfh_pkg::PAGE_ENT_W-1:0]      page_wdata;
    logic [dpfh_pkg::PAGE_ENT_W-1:0]      page_rdata;

    assign dir_idx   = addr_reg[dpfh_pkg::DIR_LO +: dpfh_pkg::DIRECTORY_BITS];
    assign sec_idx   = addr_reg[dpfh_pkg::PAGE_SHIFT +: dpfh_pkg::SECOND_BITS];
    assign slot_addr = {table_reg, sec_idx};

    dpfh_cmp u_cmp (
        .addr (addr_reg),
        .cfg  (cfg_reg),
        .sel  (sel_reg),
        .lt   (cmp_lt)
    );

    dpfh_ram #(
        .WIDTH (dpfh_pkg::DIR_ENT_W),
        .DEPTH (dpfh_pkg::DIR_SIZE)
    ) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .raddr (dir_idx),
        .rdata (dir_rdata)
    );

    dpfh_ram #(
        .WIDTH (dpfh_pkg::PAGE_ENT_W),
        .DEPTH (dpfh_pkg::SLOT_DEPTH)
    ) u_page_ram (
        .clk   (clk),
        .we    (page_we),
        .waddr (page_waddr),
        .wdata (page_wdata),
        .raddr (slot_addr),
        .rdata (page_rdata)
    );

    // rights of the region the address falls in
    always_comb
    begin
        priority if (lt_vs_reg)
        begin
            region_calc = dpfh_pkg::RIGHTS_FULL;
        end
        else if (root_reg)
        begin
            region_calc = dpfh_pkg::RIGHTS_NONE;
        end
        else if (!lt_hs_reg && lt_he_reg)
        begin
            region_calc = dpfh_pkg::RIGHTS_RW;
        end
        else if (gt_se_reg && !gt_st_reg)
        begin
            region_calc = dpfh_pkg::RIGHTS_RW;
        end
        else
        begin
            region_calc = dpfh_pkg::RIGHTS_NONE;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cfg_next        = cfg_reg;
        clr_next        = clr_reg;
        tiu_next        = tiu_reg;
        sel_next        = sel_reg;
        addr_next       = addr_reg;
        want_next       = want_reg;
        root_next       = root_reg;
        offer_next      = offer_reg;
        avail_next      = avail_reg;
        lt_vs_next      = lt_vs_reg;
        lt_hs_next      = lt_hs_reg;
        lt_he_next      = lt_he_reg;
        gt_se_next      = gt_se_reg;
        gt_st_next      = gt_st_reg;
        table_next      = table_reg;
        region_next     = region_reg;
        res_frame_next  = res_frame_reg;
        res_rights_next = res_rights_reg;
        res_taken_next  = res_taken_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg;
        page_out_next   = page_out_reg;
        frame_out_next  = frame_out_reg;
        rights_out_next = rights_out_reg;
        denied_next     = denied_reg;
        taken_out_next  = taken_out_reg;
        status_out_next = status_out_reg;

        dir_we     = 1'b0;
        dir_waddr  = dir_idx;
        dir_wdata  = {1'b1, tiu_reg[dpfh_pkg::TBL_W-1:0]};
        page_we    = 1'b0;
        page_waddr = slot_addr;
        page_wdata = {1'b1, offer_reg};

        if (cfg_valid)
        begin
            unique case (cfg_index)
                dpfh_pkg::REG_VSTART: cfg_next.vstart = cfg_data;
                dpfh_pkg::REG_HSTART: cfg_next.hstart = cfg_data;
                dpfh_pkg::REG_HEND:   cfg_next.hend   = cfg_data;
                dpfh_pkg::REG_SEND:   cfg_next.send   = cfg_data;
                dpfh_pkg::REG_STOP:   cfg_next.stop   = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                dir_we     = 1'b1;
                dir_waddr  = clr_reg[dpfh_pkg::DIRECTORY_BITS-1:0];
                dir_wdata  = '0;
                page_we    = 1'b1;
                page_waddr = clr_reg[dpfh_pkg::SLOT_AW-1:0];
                page_wdata = '0;
                if (clr_reg == dpfh_pkg::CLR_W'(dpfh_pkg::CLR_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + dpfh_pkg::CLR_W'(1);
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    addr_next  = fault_address;
                    want_next  = access_wanted;
                    root_next  = requester_is_root;
                    offer_next = offered_frame;
                    avail_next = frame_available;
                    sel_next   = dpfh_pkg::CMP_VSTART;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                unique case (sel_reg)
                    dpfh_pkg::CMP_VSTART:
                    begin
                        lt_vs_next = cmp_lt;
                        sel_next   = dpfh_pkg::CMP_HSTART;
                    end
                    dpfh_pkg::CMP_HSTART:
                    begin
                        lt_hs_next = cmp_lt;
                        sel_next   = dpfh_pkg::CMP_HEND;
                    end
                    dpfh_pkg::CMP_HEND:
                    begin
                        lt_he_next = cmp_lt;
                        sel_next   = dpfh_pkg::CMP_SEND;
                    end
                    dpfh_pkg::CMP_SEND:
                    begin
                        gt_se_next = cmp_lt;
                        sel_next   = dpfh_pkg::CMP_STOP;
                    end
                    dpfh_pkg::CMP_STOP:
                    begin
                        gt_st_next = cmp_lt;
                        state_next = S_DIR;
                    end
                    default:
                    begin
                        sel_next = dpfh_pkg::CMP_VSTART;
                    end
                endcase
            end
            S_DIR:
            begin
                region_next    = region_calc;
                res_taken_next = 1'b0;
                priority if (lt_vs_reg)
                begin
                    res_frame_next  = addr_reg[dpfh_pkg::ADDR_W-1:dpfh_pkg::PAGE_SHIFT];
                    res_rights_next = dpfh_pkg::RIGHTS_FULL;
                    res_status_next = dpfh_pkg::ST_DIRECT;
                    state_next      = S_OUT;
                end
                else if (dir_rdata[dpfh_pkg::TBL_W])
                begin
                    table_next = dir_rdata[dpfh_pkg::TBL_W-1:0];
                    state_next = S_PWAIT;
                end
                else if (tiu_reg < dpfh_pkg::TIU_W'(dpfh_pkg::TABLE_POOL))
                begin
                    // new table; its entries are still clear from reset
                    dir_we     = 1'b1;
                    table_next = tiu_reg[dpfh_pkg::TBL_W-1:0];
                    tiu_next   = tiu_reg + dpfh_pkg::TIU_W'(1);
                    state_next = S_PWAIT;
                end
                else
                begin
                    res_frame_next  = '0;
                    res_rights_next = dpfh_pkg::RIGHTS_NONE;
                    res_status_next = dpfh_pkg::ST_NO_TABLE;
                    state_next      = S_OUT;
                end
            end
            S_PWAIT:
            begin
                state_next = S_PAGE;
            end
            S_PAGE:
            begin
                priority if (page_rdata[dpfh_pkg::FRAME_W])
                begin
                    res_frame_next  = page_rdata[dpfh_pkg::FRAME_W-1:0];
                    res_rights_next = region_reg;
                    res_status_next = dpfh_pkg::ST_EXISTING;
                end
                else if (avail_reg)
                begin
                    page_we         = 1'b1;
                    res_frame_next  = offer_reg;
                    res_rights_next = region_reg;
                    res_taken_next  = 1'b1;
                    res_status_next = dpfh_pkg::ST_NEW;
                end
                else
                begin
                    res_frame_next  = '0;
                    res_rights_next = dpfh_pkg::RIGHTS_NONE;
                    res_status_next = dpfh_pkg::ST_NO_FRAME;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    page_out_next   = addr_reg[dpfh_pkg::ADDR_W-1:dpfh_pkg::PAGE_SHIFT];
                    frame_out_next  = res_frame_reg;
                    rights_out_next = res_rights_reg;
                    denied_next     = ((want_reg & {1'b0, region_reg}) != want_reg);
                    taken_out_next  = res_taken_reg;
                    status_out_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cfg_reg.vstart <= dpfh_pkg::VSTART_RST;
            cfg_reg.hstart <= dpfh_pkg::HSTART_RST;
            cfg_reg.hend   <= dpfh_pkg::HEND_RST;
            cfg_reg.send   <= dpfh_pkg::SEND_RST;
            cfg_reg.stop   <= dpfh_pkg::STOP_RST;
            clr_reg        <= '0;
            tiu_reg        <= '0;
            sel_reg        <= dpfh_pkg::CMP_VSTART;
            addr_reg       <= '0;
            want_reg       <= '0;
            root_reg       <= 1'b0;
            offer_reg      <= '0;
            avail_reg      <= 1'b0;
            lt_vs_reg      <= 1'b0;
            lt_hs_reg      <= 1'b0;
            lt_he_reg      <= 1'b0;
            gt_se_reg      <= 1'b0;
            gt_st_reg      <= 1'b0;
            table_reg      <= '0;
            region_reg     <= '0;
            res_frame_reg  <= '0;
            res_rights_reg <= '0;
            res_taken_reg  <= 1'b0;
            res_status_reg <= dpfh_pkg::ST_DIRECT;
            out_valid_reg  <= 1'b0;
            page_out_reg   <= '0;
            frame_out_reg  <= '0;
            rights_out_reg <= '0;
            denied_reg     <= 1'b0;
            taken_out_reg  <= 1'b0;
            status_out_reg <= dpfh_pkg::ST_DIRECT;
        end
        else
        begin
            state_reg      <= state_next;
            cfg_reg        <= cfg_next;
            clr_reg        <= clr_next;
            tiu_reg        <= tiu_next;
            sel_reg        <= sel_next;
            addr_reg       <= addr_next;
            want_reg       <= want_next;
            root_reg       <= root_next;
            offer_reg      <= offer_next;
            avail_reg      <= avail_next;
            lt_vs_reg      <= lt_vs_next;
            lt_hs_reg      <= lt_hs_next;
            lt_he_reg      <= lt_he_next;
            gt_se_reg      <= gt_se_next;
            gt_st_reg      <= gt_st_next;
            table_reg      <= table_next;
            region_reg     <= region_next;
            res_frame_reg  <= res_frame_next;
            res_rights_reg <= res_rights_next;
            res_taken_reg  <= res_taken_next;
            res_status_reg <= res_status_next;
            out_valid_reg  <= out_valid_next;
            page_out_reg   <= page_out_next;
            frame_out_reg  <= frame_out_next;
            rights_out_reg <= rights_out_next;
            denied_reg     <= denied_next;
            taken_out_reg  <= taken_out_next;
            status_out_reg <= status_out_next;
        end
    end

    assign cfg_ready      = 1'b1;
    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = out_valid_reg;
    assign virtual_page   = page_out_reg;
    assign physical_frame = frame_out_reg;
    assign rights         = rights_out_reg;
    assign access_denied  = denied_reg;
    assign frame_taken    = taken_out_reg;
    assign status         = status_out_reg;

    `DPFH_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready while busy")
    `DPFH_ASSERT_IMP(a_no_accept_in_clear, state_reg == S_CLEAR, !in_ready, "ready in clear")
    `DPFH_ASSERT_IMP(a_pool_bound, 1'b1,
        tiu_reg <= dpfh_pkg::TIU_W'(dpfh_pkg::TABLE_POOL), "pool overrun")
    `DPFH_ASSERT_IMP(a_taken_is_new, out_valid,
        frame_taken == (status == dpfh_pkg::ST_NEW), "taken mismatch")
    `DPFH_ASSERT_IMP(a_direct_map, out_valid && status == dpfh_pkg::ST_DIRECT,
        physical_frame == virtual_page && rights == dpfh_pkg::RIGHTS_FULL, "direct map mismatch")

endmodule
